FILE: hw/rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and codes for the precharge sequence controller.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int TICKS_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PHASE_WIDTH = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRECHARGE_TICKS       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DISCHARGE_TICKS       = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FORWARD_DISABLE_TICKS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [TICKS_WIDTH-1:0] PRECHARGE_TICKS_RESET       = 16'd5;
    localparam logic [TICKS_WIDTH-1:0] DISCHARGE_TICKS_RESET       = 16'd10;
    localparam logic [TICKS_WIDTH-1:0] FORWARD_DISABLE_TICKS_RESET = 16'd5000;

    // Sequencer phase codes, also reported as the mode field.
    localparam logic [PHASE_WIDTH-1:0] PH_OFF         = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_ESTOP       = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_PRECHARGE   = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_CLOSE       = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_ON          = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_OPEN        = 3'd5;
    localparam logic [PHASE_WIDTH-1:0] PH_DISCHARGE   = 3'd6;
    localparam logic [PHASE_WIDTH-1:0] PH_FWD_DISABLE = 3'd7;

    typedef struct packed {
        logic [TICKS_WIDTH-1:0] precharge_ticks;
        logic [TICKS_WIDTH-1:0] discharge_ticks;
        logic [TICKS_WIDTH-1:0] forward_disable_ticks;
    } cfg_t;

    typedef struct packed {
        logic precharge;
        logic discharge;
        logic contactor;
        logic apm;
        logic forward;
    } drive_t;

endpackage

FILE: hw/rtl/psc_if.sv
// ----------------------------------------------------------------------------
// psc_if
// Handshake channels of the precharge sequence controller.
// ----------------------------------------------------------------------------
interface psc_tick_if;
    logic valid;
    logic ready;
    logic key_on;
    logic battery_one_ok;
    logic battery_two_ok;
    logic estop_pressed;

    modport source (
        output valid, key_on, battery_one_ok, battery_two_ok, estop_pressed,
        input  ready
    );
    modport sink (
        input  valid, key_on, battery_one_ok, battery_two_ok, estop_pressed,
        output ready
    );
endinterface

interface psc_result_if;
    logic                            valid;
    logic                            ready;
    logic                            precharge_on;
    logic                            discharge_on;
    logic                            contactor_closed;
    logic                            apm_on;
    logic                            forward_on;
    logic                            safe_torque_ok;
    logic [psc_pkg::PHASE_WIDTH-1:0] mode;

    modport source (
        output valid, precharge_on, discharge_on, contactor_closed, apm_on,
               forward_on, safe_torque_ok, mode,
        input  ready
    );
    modport sink (
        input  valid, precharge_on, discharge_on, contactor_closed, apm_on,
               forward_on, safe_torque_ok, mode,
        output ready
    );
endinterface

interface psc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [psc_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [psc_pkg::TICKS_WIDTH-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: hw/rtl/psc_seq.sv
// ----------------------------------------------------------------------------
// psc_seq
// Phase sequencer with wait counter and latched relay drives.
// ----------------------------------------------------------------------------
module psc_seq #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            key,
    input  logic                            sto,
    input  psc_pkg::cfg_t                   cfg,
    output psc_pkg::drive_t                 drive_next,
    output logic [psc_pkg::PHASE_WIDTH-1:0] phase_next
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > psc_pkg::TICKS_WIDTH) ?
                               COUNT_WIDTH : psc_pkg::TICKS_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [psc_pkg::PHASE_WIDTH-1:0] phase_reg;
    logic [COUNT_WIDTH-1:0]          count_reg;
    logic [COUNT_WIDTH-1:0]          count_next;
    psc_pkg::drive_t                 drive_reg;

    logic [COUNT_WIDTH-1:0]          count_inc;
    logic [psc_pkg::TICKS_WIDTH-1:0] limit;
    logic                            wait_done;
    logic                            drop;

    assign drop = !sto || !key;

    // The counter saturates; reaching all ones also ends a wait.
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        unique case (phase_reg)
            psc_pkg::PH_PRECHARGE: limit = cfg.precharge_ticks;
            psc_pkg::PH_DISCHARGE: limit = cfg.discharge_ticks;
            default:               limit = cfg.forward_disable_ticks;
        endcase
    end

    // A limit of zero ends the wait on the first tick, as count_inc is never zero.
    assign wait_done = (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(limit)) ||
                       (count_inc == COUNT_MAX);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        drive_next = drive_reg;
        unique case (phase_reg)
            psc_pkg::PH_OFF:
            begin
                if (!sto)
                begin
                    phase_next = psc_pkg::PH_ESTOP;
                end
                else if (key)
                begin
                    phase_next = psc_pkg::PH_PRECHARGE;
                    drive_next.precharge = 1'b1;
                    count_next = '0;
                end
            end
            psc_pkg::PH_ESTOP:
            begin
                if (sto)
                begin
                    phase_next = psc_pkg::PH_OFF;
                end
            end
            psc_pkg::PH_PRECHARGE:
            begin
                count_next = wait_done ? '0 : count_inc;
                if (wait_done)
                begin
                    drive_next.precharge = 1'b0;
                    phase_next = drop ? psc_pkg::PH_OPEN : psc_pkg::PH_CLOSE;
                end
            end
            psc_pkg::PH_CLOSE:
            begin
                drive_next.contactor = 1'b1;
                drive_next.forward = 1'b1;
                drive_next.apm = 1'b1;
                phase_next = drop ? psc_pkg::PH_OPEN : psc_pkg::PH_ON;
            end
            psc_pkg::PH_ON:
            begin
                if (drop)
                begin
                    phase_next = psc_pkg::PH_FWD_DISABLE;
                    drive_next.forward = 1'b0;
                    count_next = '0;
                end
            end
            psc_pkg::PH_OPEN:
            begin
                drive_next.contactor = 1'b0;
                drive_next.discharge = 1'b1;
                phase_next = psc_pkg::PH_DISCHARGE;
                count_next = '0;
            end
            psc_pkg::PH_DISCHARGE:
            begin
                count_next = wait_done ? '0 : count_inc;
                if (wait_done)
                begin
                    drive_next.discharge = 1'b0;
                    phase_next = psc_pkg::PH_OFF;
                end
            end
            psc_pkg::PH_FWD_DISABLE:
            begin
                count_next = wait_done ? '0 : count_inc;
                if (wait_done)
                begin
                    drive_next.apm = 1'b0;
                    phase_next = psc_pkg::PH_OPEN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= psc_pkg::PH_OFF;
            count_reg <= '0;
            drive_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            drive_reg <= drive_next;
        end
    end

endmodule

FILE: hw/rtl/precharge_sequence_controller.sv
// ----------------------------------------------------------------------------
// precharge_sequence_controller
// Key and battery driven precharge, contactor and discharge sequencer.
// ----------------------------------------------------------------------------
// Each tick transaction produces exactly one result transaction, in the
// cycle after it is accepted, and a new tick is accepted in every cycle: the
// phase register, wait counter and latched drives are updated in the same
// cycle the tick is taken, and the result sits in an output register so a
// tick is still taken while a result waits, as long as that result leaves in
// the same cycle. The wait lengths are tick counts in three registers written
// through the configuration channel, which is always ready; write them only
// while no tick is in flight.
module precharge_sequence_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    psc_tick_if.sink     tick,
    psc_result_if.source result,
    psc_cfg_if.sink      cfg
);

    psc_pkg::cfg_t                   cfg_reg;
    logic                            result_valid_reg;
    psc_pkg::drive_t                 drive_out_reg;
    logic                            sto_out_reg;
    logic [psc_pkg::PHASE_WIDTH-1:0] mode_out_reg;

    psc_pkg::drive_t                 drive_next;
    logic [psc_pkg::PHASE_WIDTH-1:0] phase_next;
    logic                            sto;
    logic                            step;

    assign sto  = tick.battery_one_ok && tick.battery_two_ok && !tick.estop_pressed;
    assign tick.ready = !result_valid_reg || result.ready;
    assign step = tick.valid && tick.ready;
    assign cfg.ready = 1'b1;

    psc_seq #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .key       (tick.key_on),
        .sto       (sto),
        .cfg       (cfg_reg),
        .drive_next(drive_next),
        .phase_next(phase_next)
    );

    // Writes to an index past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.precharge_ticks       <= psc_pkg::PRECHARGE_TICKS_RESET;
            cfg_reg.discharge_ticks       <= psc_pkg::DISCHARGE_TICKS_RESET;
            cfg_reg.forward_disable_ticks <= psc_pkg::FORWARD_DISABLE_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == psc_pkg::CFG_PRECHARGE_TICKS)
            begin
                cfg_reg.precharge_ticks <= cfg.data;
            end
            else if (cfg.index == psc_pkg::CFG_DISCHARGE_TICKS)
            begin
                cfg_reg.discharge_ticks <= cfg.data;
            end
            else if (cfg.index == psc_pkg::CFG_FORWARD_DISABLE_TICKS)
            begin
                cfg_reg.forward_disable_ticks <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            result_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            drive_out_reg <= drive_next;
            sto_out_reg   <= sto;
            mode_out_reg  <= phase_next;
        end
    end

    assign result.valid            = result_valid_reg;
    assign result.precharge_on     = drive_out_reg.precharge;
    assign result.discharge_on     = drive_out_reg.discharge;
    assign result.contactor_closed = drive_out_reg.contactor;
    assign result.apm_on           = drive_out_reg.apm;
    assign result.forward_on       = drive_out_reg.forward;
    assign result.safe_torque_ok   = sto_out_reg;
    assign result.mode             = mode_out_reg;

endmodule

FILE: tb/sv/precharge_sequence_controller_tb.sv
// ----------------------------------------------------------------------------
// precharge_sequence_controller_tb
// Self-checking testbench for the precharge sequence controller. A scripted
// walk covers the estop, off, precharge, close, on, forward-disable, open and
// discharge phases and the register corner cases. Runs of random ticks follow
// under several register settings, including the all-ones extreme. Every
// result transaction is compared with a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module precharge_sequence_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int COUNT_WIDTH     = 16;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int LONG_HOLD       = 300;
    localparam int NUM_PHASES      = 6;
    localparam int EXTREME_PHASE   = 2;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int TAIL_CYCLES     = 10;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic [COUNT_WIDTH-1:0]     COUNT_FULL       = '1;

    // Register plan for the random phases; a negative entry draws a small value.
    localparam int PLAN_PRECHARGE [NUM_PHASES] = '{1, -1, 65535, 0, -1, 2};
    localparam int PLAN_DISCHARGE [NUM_PHASES] = '{1, -1, 65535, 3, -1, 0};
    localparam int PLAN_FWD_DIS   [NUM_PHASES] = '{1, -1, 65535, 0, -1, 40};

    typedef struct packed {
        logic key;
        logic batt_one;
        logic batt_two;
        logic estop;
    } pins_t;

    typedef struct packed {
        drive_t                 drv;
        logic                   sto;
        logic [PHASE_WIDTH-1:0] mode;
    } outcome_t;

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        pins_t                      pins;
        logic [15:0]                reps;
        bit                         typed;
        outcome_t                   want;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [TICKS_WIDTH-1:0]     data;
    } script_row_t;

    localparam pins_t PINS_OK_ON  = 4'b1110;
    localparam pins_t PINS_OK_OFF = 4'b0110;

    localparam int SCRIPT_LEN = 27;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ROW_TICK,  4'b1111, 16'd1,    1'b1, '{'0, 1'b0, PH_ESTOP}, '0, '0},
        '{ROW_TICK,  4'b1010, 16'd1,    1'b1, '{'0, 1'b0, PH_ESTOP}, '0, '0},
        '{ROW_TICK,  4'b0100, 16'd1,    1'b1, '{'0, 1'b0, PH_ESTOP}, '0, '0},
        '{ROW_TICK,  4'b0110, 16'd1,    1'b1, '{'0, 1'b1, PH_OFF}, '0, '0},
        '{ROW_TICK,  4'b0110, 16'd1,    1'b1, '{'0, 1'b1, PH_OFF}, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd1,    1'b1,
          '{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, PH_PRECHARGE}, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd3,    1'b0, '0, '0, '0},
        // Key drops late in precharge: the decision takes the final tick's key.
        '{ROW_TICK,  4'b0110, 16'd2,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd11,   1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd6,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd4,    1'b0, '0, '0, '0},
        // A short forward-disable wait keeps the walk brief.
        '{ROW_WRITE, 4'b0000, 16'd0,    1'b0, '0, CFG_FORWARD_DISABLE_TICKS, 16'd30},
        '{ROW_TICK,  4'b1111, 16'd1,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b0001, 16'd30,   1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd1,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b0110, 16'd10,   1'b0, '0, '0, '0},
        '{ROW_WRITE, 4'b0000, 16'd0,    1'b0, '0, CFG_PRECHARGE_TICKS, 16'd0},
        '{ROW_WRITE, 4'b0000, 16'd0,    1'b0, '0, CFG_DISCHARGE_TICKS, 16'd0},
        '{ROW_WRITE, 4'b0000, 16'd0,    1'b0, '0, CFG_FORWARD_DISABLE_TICKS, 16'd0},
        '{ROW_WRITE, 4'b0000, 16'd0,    1'b0, '0, CFG_UNUSED_INDEX, 16'hFFFF},
        '{ROW_TICK,  4'b1110, 16'd2,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1100, 16'd1,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd3,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1110, 16'd3,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b0110, 16'd4,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b1010, 16'd2,    1'b0, '0, '0, '0},
        '{ROW_TICK,  4'b0110, 16'd2,    1'b0, '0, '0, '0}
    };

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   mismatches;
    bit   long_hold_req;
    logic cruise_key;

    // Model state of the sequencer.
    cfg_t                   held_cfg;
    logic [PHASE_WIDTH-1:0] seq_phase;
    logic [COUNT_WIDTH-1:0] hold_count;
    drive_t                 latched_drv;

    outcome_t pending_outcomes[$];

    psc_tick_if   tick_ch ();
    psc_result_if result_ch ();
    psc_cfg_if    cfg_ch ();

    precharge_sequence_controller #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Count one wait tick; the counter saturates, and reaching the limit or
    // saturation both end the wait. A limit of zero ends it at once.
    function automatic bit hold_elapsed(input logic [TICKS_WIDTH-1:0] limit);
        if (hold_count != COUNT_FULL)
            hold_count = hold_count + 1'b1;
        if (hold_count >= limit || hold_count == COUNT_FULL)
        begin
            hold_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic outcome_t advance_sequencer(input pins_t p);
        logic     sto;
        logic     drop;
        outcome_t o;
        sto  = p.batt_one & p.batt_two & ~p.estop;
        drop = ~sto | ~p.key;
        case (seq_phase)
            PH_OFF:
            begin
                if (!sto)
                    seq_phase = PH_ESTOP;
                else if (p.key)
                begin
                    seq_phase             = PH_PRECHARGE;
                    latched_drv.precharge = 1'b1;
                    hold_count            = '0;
                end
            end
            PH_ESTOP:
            begin
                if (sto)
                    seq_phase = PH_OFF;
            end
            PH_PRECHARGE:
            begin
                if (hold_elapsed(held_cfg.precharge_ticks))
                begin
                    latched_drv.precharge = 1'b0;
                    seq_phase             = drop ? PH_OPEN : PH_CLOSE;
                end
            end
            PH_CLOSE:
            begin
                latched_drv.contactor = 1'b1;
                latched_drv.forward   = 1'b1;
                latched_drv.apm       = 1'b1;
                seq_phase             = drop ? PH_OPEN : PH_ON;
            end
            PH_ON:
            begin
                if (drop)
                begin
                    seq_phase           = PH_FWD_DISABLE;
                    latched_drv.forward = 1'b0;
                    hold_count          = '0;
                end
            end
            PH_OPEN:
            begin
                latched_drv.contactor = 1'b0;
                latched_drv.discharge = 1'b1;
                seq_phase             = PH_DISCHARGE;
                hold_count            = '0;
            end
            PH_DISCHARGE:
            begin
                if (hold_elapsed(held_cfg.discharge_ticks))
                begin
                    latched_drv.discharge = 1'b0;
                    seq_phase             = PH_OFF;
                end
            end
            default:
            begin
                if (hold_elapsed(held_cfg.forward_disable_ticks))
                begin
                    latched_drv.apm = 1'b0;
                    seq_phase       = PH_OPEN;
                end
            end
        endcase
        o.drv  = latched_drv;
        o.sto  = sto;
        o.mode = seq_phase;
        return o;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                           input logic [TICKS_WIDTH-1:0] value);
        case (idx)
            CFG_PRECHARGE_TICKS:       held_cfg.precharge_ticks       = value;
            CFG_DISCHARGE_TICKS:       held_cfg.discharge_ticks       = value;
            CFG_FORWARD_DISABLE_TICKS: held_cfg.forward_disable_ticks = value;
            default: ;
        endcase
    endfunction

    // Mostly zero, sometimes a few cycles, rarely a long pause.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Sticky key with healthy batteries most of the time, so that sequences
    // reach the on phase; one tick in ten is pure noise.
    function automatic pins_t draw_pins();
        pins_t p;
        if ($urandom_range(0, 9) == 0)
            return pins_t'($urandom_range(0, 15));
        if ($urandom_range(0, 15) == 0)
            cruise_key = ~cruise_key;
        p.key      = cruise_key;
        p.batt_one = ($urandom_range(0, 39) != 0);
        p.batt_two = ($urandom_range(0, 39) != 0);
        p.estop    = ($urandom_range(0, 39) == 0);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic offer_tick(input pins_t p, input bit typed, input outcome_t want);
        int       gap;
        outcome_t predicted;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            tick_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        tick_ch.valid          <= 1'b1;
        tick_ch.key_on         <= p.key;
        tick_ch.battery_one_ok <= p.batt_one;
        tick_ch.battery_two_ok <= p.batt_two;
        tick_ch.estop_pressed  <= p.estop;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        predicted = advance_sequencer(p);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    // Stop offering ticks and wait for every outstanding result.
    task automatic settle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [TICKS_WIDTH-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_register(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic check_result();
        outcome_t want;
        if (pending_outcomes.size() == 0)
        begin
            report_mismatch($sformatf("result transaction with mode %0d was not expected",
                                      result_ch.mode));
            return;
        end
        want = pending_outcomes.pop_front();
        compare_field("precharge_on", result_ch.precharge_on, want.drv.precharge);
        compare_field("discharge_on", result_ch.discharge_on, want.drv.discharge);
        compare_field("contactor_closed", result_ch.contactor_closed, want.drv.contactor);
        compare_field("apm_on", result_ch.apm_on, want.drv.apm);
        compare_field("forward_on", result_ch.forward_on, want.drv.forward);
        compare_field("safe_torque_ok", result_ch.safe_torque_ok, want.sto);
        compare_field("mode", result_ch.mode, want.mode);
    endtask

    // Result side: random back-pressure, plus the occasional long hold-off
    // that lets the output register fill and stalls the tick channel.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                check_result();
                stall_left = gap_len();
            end
        end
    end

    initial
    begin
        cycle_count              = 0;
        mismatches               = 0;
        long_hold_req            = 1'b0;
        cruise_key               = 1'b1;
        held_cfg.precharge_ticks       = PRECHARGE_TICKS_RESET;
        held_cfg.discharge_ticks       = DISCHARGE_TICKS_RESET;
        held_cfg.forward_disable_ticks = FORWARD_DISABLE_TICKS_RESET;
        seq_phase                = PH_OFF;
        hold_count               = '0;
        latched_drv              = '0;
        rst_n                    = 1'b0;
        tick_ch.valid            = 1'b0;
        tick_ch.key_on           = 1'b0;
        tick_ch.battery_one_ok   = 1'b0;
        tick_ch.battery_two_ok   = 1'b0;
        tick_ch.estop_pressed    = 1'b0;
        result_ch.ready          = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = '0;
        cfg_ch.data              = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].kind == ROW_WRITE)
            begin
                settle();
                write_register(SCRIPT[i].index, SCRIPT[i].data);
            end
            else
            begin
                for (int n = 0; n < SCRIPT[i].reps; n++)
                    offer_tick(SCRIPT[i].pins, SCRIPT[i].typed, SCRIPT[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Park in off before the all-ones setting so that a long wait
            // does not start in the forward-disable or discharge phase.
            if (ph == EXTREME_PHASE)
                while (seq_phase != PH_OFF)
                    offer_tick(PINS_OK_OFF, 1'b0, '0);
            settle();
            write_register(CFG_PRECHARGE_TICKS, PLAN_PRECHARGE[ph] < 0 ?
                           TICKS_WIDTH'($urandom_range(1, 12)) : TICKS_WIDTH'(PLAN_PRECHARGE[ph]));
            write_register(CFG_DISCHARGE_TICKS, PLAN_DISCHARGE[ph] < 0 ?
                           TICKS_WIDTH'($urandom_range(1, 12)) : TICKS_WIDTH'(PLAN_DISCHARGE[ph]));
            write_register(CFG_FORWARD_DISABLE_TICKS, PLAN_FWD_DIS[ph] < 0 ?
                           TICKS_WIDTH'($urandom_range(1, 12)) : TICKS_WIDTH'(PLAN_FWD_DIS[ph]));
            if ($urandom_range(0, 1) == 1)
                write_register(CFG_UNUSED_INDEX, TICKS_WIDTH'($urandom));
            if (ph == 0 || ph == 4)
                long_hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE)
                offer_tick(draw_pins(), 1'b0, '0);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
